// ===== hdl/hbe_pkg.sv =====
// Shared constants and types of the Huffman byte encoder.
`default_nettype none
package hbe_pkg;

  localparam int SYMBOLS          = 256;
  localparam int SYM_W            = 8;
  localparam int CODE_BITS        = 24;
  localparam int LEN_W            = 5;
  localparam int PEND_W           = 7;
  localparam int ACC_W            = PEND_W + CODE_BITS;
  localparam int ALIGN_W          = 32;
  localparam int SHIFT_W          = 6;
  localparam int BYTE_W           = 8;
  localparam int NBYTE_W          = 3;
  localparam int IN_TDATA_W       = 40;
  localparam int MAX_CODE_LEN_DEF = 24;

  localparam logic [SYM_W-1:0] END_SYMBOL = 8'h03;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FINISH = 2'd2
  } mode_t;

endpackage
`default_nettype wire

// ===== hdl/hbe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/huffman_byte_encoder_top.sv =====
// Top level of the table-driven Huffman byte encoder.
// An encode or finish request reads the code store into its registered read data, then loads
// the output shift register once the byte emitter is free; the first byte leaves from there.
// Throughput: one output byte a cycle while out_tready is high; an encode emits up to three
// bytes and a finish up to four. Loads write the code store in the accept cycle.
// Reset clears all per-entry valid flags at once: every code reads as zero length.
`default_nettype none
module huffman_byte_encoder_top #(
  parameter int MAX_CODE_LEN = hbe_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // mode[1:0], symbol[9:2], code_word[33:10], code_length[38:34], zero[39]
  input  wire logic [hbe_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_byte[7:0]
  output logic      [hbe_pkg::BYTE_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  // stream_end[0]
  output logic                                  out_tuser
);
  import hbe_pkg::*;

  localparam int STORE_W = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(STORE_W);
  localparam int ENTRY_W = STORE_W + LEN_W;

  logic [1:0]           in_mode;
  logic [SYM_W-1:0]     in_symbol;
  logic [CODE_BITS-1:0] in_code_word;
  logic [LEN_W-1:0]     in_code_length;
  logic [LEN_W-1:0]     load_len;
  logic                 in_acc;
  logic                 wr_en;
  logic                 rd_en;
  logic [SYM_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]   rd_data;

  logic [SYMBOLS-1:0]   valid_r;
  logic                 rd_vld_r;
  logic                 a_vld_r, a_vld_nxt;
  logic                 a_fin_r, a_fin_nxt;
  logic [ALIGN_W-1:0]   shf_r, shf_nxt;
  logic [NBYTE_W-1:0]   nbytes_r, nbytes_nxt;
  logic                 fin_r, fin_nxt;
  logic [PEND_W-1:0]    pend_bits_r, pend_bits_nxt;
  logic [2:0]           pend_cnt_r, pend_cnt_nxt;

  logic                 b_free;
  logic                 b_load;
  logic [LEN_W-1:0]     cur_len;
  logic [ACC_W-1:0]     code_ext;
  logic [ACC_W-1:0]     acc;
  logic [LEN_W-1:0]     cnt;
  logic [SHIFT_W-1:0]   shamt;
  logic [PEND_W-1:0]    pend_mask;

  assign in_mode        = in_tdata[1:0];
  assign in_symbol      = in_tdata[9:2];
  assign in_code_word   = in_tdata[33:10];
  assign in_code_length = in_tdata[38:34];
  assign load_len       = (in_code_length > LEN_LIMIT) ? LEN_LIMIT : in_code_length;

  assign b_free    = (nbytes_r == '0) || ((nbytes_r == NBYTE_W'(1)) && out_tready);
  assign b_load    = a_vld_r && b_free;
  assign in_tready = !a_vld_r || b_free;
  assign in_acc    = in_tvalid && in_tready;

  assign wr_en   = in_acc && (in_mode == MODE_LOAD);
  assign rd_en   = in_acc && ((in_mode == MODE_ENCODE) || (in_mode == MODE_FINISH));
  assign rd_addr = (in_mode == MODE_FINISH) ? END_SYMBOL : in_symbol;

  hbe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOLS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_symbol),
    .wr_data ({in_code_word[STORE_W-1:0], load_len}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[in_symbol] <= 1'b1;
    end
    if (rd_en) begin
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  always_comb begin
    a_vld_nxt = a_vld_r;
    a_fin_nxt = a_fin_r;
    if (b_load) begin
      a_vld_nxt = 1'b0;
    end
    if (rd_en) begin
      a_vld_nxt = 1'b1;
      a_fin_nxt = (in_mode == MODE_FINISH);
    end
  end

  always_comb begin
    cur_len   = rd_vld_r ? rd_data[LEN_W-1:0] : '0;
    code_ext  = ACC_W'(rd_data[ENTRY_W-1:LEN_W]) & ~({ACC_W{1'b1}} << cur_len);
    acc       = (ACC_W'(pend_bits_r) << cur_len) | code_ext;
    cnt       = LEN_W'(pend_cnt_r) + cur_len;
    shamt     = SHIFT_W'(ALIGN_W) - SHIFT_W'(cnt);
    pend_mask = ~({PEND_W{1'b1}} << cnt[2:0]);

    shf_nxt       = shf_r;
    nbytes_nxt    = nbytes_r;
    fin_nxt       = fin_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (out_tvalid && out_tready) begin
      shf_nxt    = shf_r << BYTE_W;
      nbytes_nxt = nbytes_r - NBYTE_W'(1);
    end
    if (b_load) begin
      shf_nxt = ALIGN_W'(acc) << shamt;
      fin_nxt = a_fin_r;
      if (a_fin_r) begin
        nbytes_nxt    = NBYTE_W'((SHIFT_W'(cnt) + SHIFT_W'(7)) >> 3);
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
      end else begin
        nbytes_nxt    = NBYTE_W'(cnt >> 3);
        pend_bits_nxt = acc[PEND_W-1:0] & pend_mask;
        pend_cnt_nxt  = cnt[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      nbytes_r    <= '0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      a_vld_r     <= a_vld_nxt;
      nbytes_r    <= nbytes_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
    a_fin_r <= a_fin_nxt;
    shf_r   <= shf_nxt;
    fin_r   <= fin_nxt;
  end

  assign out_tvalid = (nbytes_r != '0);
  assign out_tdata  = shf_r[ALIGN_W-1 -: BYTE_W];
  assign out_tlast  = (nbytes_r == NBYTE_W'(1));
  assign out_tuser  = fin_r && (nbytes_r == NBYTE_W'(1));

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Stream testbench for the table-driven Huffman byte encoder with a built-in bit packer.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hbe_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LEN_LIMIT = (MAX_CODE_LEN_DEF < CODE_BITS) ? MAX_CODE_LEN_DEF : CODE_BITS;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              stream_end;
  } coded_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  logic [CODE_BITS-1:0] code_word_tab [SYMBOLS];
  logic [LEN_W-1:0]     code_len_tab [SYMBOLS];
  logic [PEND_W-1:0]    pend_bits = '0;
  int                   pend_cnt = 0;
  coded_byte_t          coded_bytes_due [$];

  int mismatch_count = 0;
  int send_gap_max = 8;
  int ready_stall_max = 8;

  huffman_byte_encoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < SYMBOLS; i++) begin
      code_word_tab[i] = '0;
      code_len_tab[i] = '0;
    end
  end

  function automatic void append_code(input logic [SYM_W-1:0] sym);
    int          len;
    int          cnt;
    logic [63:0] acc;
    coded_byte_t cb;
    len = code_len_tab[sym];
    acc = ({40'd0, code_word_tab[sym]} & ((64'd1 << len) - 64'd1));
    acc = ({57'd0, pend_bits} << len) | acc;
    cnt = pend_cnt + len;
    while (cnt >= BYTE_W) begin
      cb.data = acc[cnt-1 -: BYTE_W];
      cb.last = 1'b0;
      cb.stream_end = 1'b0;
      coded_bytes_due.push_back(cb);
      cnt -= BYTE_W;
    end
    pend_bits = PEND_W'(acc & ((64'd1 << cnt) - 64'd1));
    pend_cnt = cnt;
  endfunction

  function automatic void pack_request(input logic [1:0] mode, input logic [SYM_W-1:0] sym,
                                       input logic [CODE_BITS-1:0] cw,
                                       input logic [LEN_W-1:0] len);
    int          first;
    coded_byte_t cb;
    first = coded_bytes_due.size();
    case (mode)
      MODE_LOAD: begin
        code_word_tab[sym] = cw;
        code_len_tab[sym] = (len > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : len;
      end
      MODE_ENCODE: begin
        append_code(sym);
        if (coded_bytes_due.size() > first) begin
          cb = coded_bytes_due.pop_back();
          cb.last = 1'b1;
          coded_bytes_due.push_back(cb);
        end
      end
      MODE_FINISH: begin
        append_code(END_SYMBOL);
        if (pend_cnt > 0) begin
          cb.data = BYTE_W'({1'b0, pend_bits} << (BYTE_W - pend_cnt));
          cb.last = 1'b0;
          cb.stream_end = 1'b0;
          coded_bytes_due.push_back(cb);
        end
        pend_bits = '0;
        pend_cnt = 0;
        if (coded_bytes_due.size() > first) begin
          cb = coded_bytes_due.pop_back();
          cb.last = 1'b1;
          cb.stream_end = 1'b1;
          coded_bytes_due.push_back(cb);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] mode, input logic [SYM_W-1:0] sym,
                              input logic [CODE_BITS-1:0] cw, input logic [LEN_W-1:0] len);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {1'b0, len, cw, sym, mode};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pack_request(mode, sym, cw, len);
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (coded_bytes_due.size() != 0);
  endtask

  function automatic logic [LEN_W-1:0] rand_code_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return LEN_W'($urandom_range(LEN_LIMIT + 1, 31));
    if (pick < 5) return LEN_W'($urandom_range(9, LEN_LIMIT));
    return LEN_W'($urandom_range(1, 8));
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, ready_stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    coded_byte_t cb;
    if (rst_n && out_tvalid && out_tready) begin
      if (coded_bytes_due.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %02h last %0b end %0b",
                                out_tdata, out_tlast, out_tuser));
      end else begin
        cb = coded_bytes_due.pop_front();
        if (out_tdata !== cb.data)
          note_mismatch($sformatf("byte: expected %02h, got %02h", cb.data, out_tdata));
        if (out_tlast !== cb.last)
          note_mismatch($sformatf("tlast: expected %0b, got %0b", cb.last, out_tlast));
        if (out_tuser !== cb.stream_end)
          note_mismatch($sformatf("stream end: expected %0b, got %0b",
                                  cb.stream_end, out_tuser));
      end
    end
  end

  task automatic test_empty_store();
    send_request(MODE_ENCODE, 8'h00, '0, '0);
    send_request(MODE_ENCODE, 8'hFF, '0, '0);
    send_request(MODE_FINISH, '0, '0, '0);
  endtask

  task automatic test_code_extremes();
    send_request(MODE_LOAD, 8'h00, 24'hFFFFFF, 5'd24);
    send_request(MODE_LOAD, 8'hFF, 24'h000000, 5'd1);
    send_request(MODE_LOAD, 8'h80, 24'hA5A5A5, 5'd31);
    send_request(MODE_LOAD, 8'h11, 24'hFFFFF0, 5'd4);
    send_request(MODE_LOAD, 8'h22, 24'hFFFFFF, 5'd0);
    send_request(MODE_LOAD, END_SYMBOL, 24'h000005, 5'd3);
    send_request(MODE_ENCODE, 8'h00, '0, '0);
    send_request(MODE_ENCODE, 8'hFF, '0, '0);
    send_request(MODE_ENCODE, 8'h80, '0, '0);
    send_request(MODE_ENCODE, 8'h11, '0, '0);
    send_request(MODE_ENCODE, 8'h22, '0, '0);
    send_request(MODE_FINISH, '0, '0, '0);
  endtask

  task automatic test_end_marker();
    send_request(MODE_LOAD, END_SYMBOL, 24'hC3C3C3, 5'd24);
    send_request(MODE_LOAD, 8'h44, 24'h00007F, 5'd7);
    send_request(MODE_ENCODE, 8'h44, '0, '0);
    send_request(MODE_FINISH, '0, '0, '0);
    send_request(MODE_FINISH, '0, '0, '0);
    send_request(MODE_UNUSED, 8'hFF, 24'hFFFFFF, 5'h1F);
    send_request(MODE_ENCODE, 8'h44, '0, '0);
    send_request(MODE_UNUSED, 8'h44, 24'h123456, 5'd7);
    wait_for_drain();
  endtask

  task automatic test_random_stream();
    logic [SYM_W-1:0] table_syms [$];
    logic [SYM_W-1:0] sym;
    int               pick;
    for (int i = 0; i < 12; i++) begin
      sym = SYM_W'($urandom_range(0, SYMBOLS - 1));
      send_request(MODE_LOAD, sym, CODE_BITS'($urandom), rand_code_len());
      table_syms.push_back(sym);
    end
    send_request(MODE_LOAD, END_SYMBOL, CODE_BITS'($urandom), LEN_W'($urandom_range(1, 8)));
    for (int i = 0; i < 64; i++) begin
      if (i % 20 == 0) begin
        pick = $urandom_range(0, 2);
        send_gap_max = (pick == 0) ? 0 : (pick == 1) ? 2 : 8;
        pick = $urandom_range(0, 2);
        ready_stall_max = (pick == 0) ? 0 : (pick == 1) ? 2 : 8;
      end
      if (i == 45) wait_for_drain();
      pick = $urandom_range(0, 99);
      sym = table_syms[$urandom_range(0, table_syms.size() - 1)];
      if (pick < 70)
        send_request(MODE_ENCODE, sym, CODE_BITS'($urandom), LEN_W'($urandom));
      else if (pick < 78)
        send_request(MODE_ENCODE, SYM_W'($urandom), CODE_BITS'($urandom), LEN_W'($urandom));
      else if (pick < 86)
        send_request(MODE_FINISH, SYM_W'($urandom), CODE_BITS'($urandom), LEN_W'($urandom));
      else if (pick < 90)
        send_request(MODE_UNUSED, SYM_W'($urandom), CODE_BITS'($urandom), LEN_W'($urandom));
      else if (pick < 95)
        send_request(MODE_LOAD, sym, CODE_BITS'($urandom), rand_code_len());
      else
        send_request(MODE_LOAD, SYM_W'($urandom), CODE_BITS'($urandom), rand_code_len());
    end
    send_request(MODE_FINISH, '0, '0, '0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_code_extremes();
    test_end_marker();
    test_random_stream();
    wait_for_drain();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && coded_bytes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/hbe_pkg.sv
hdl/hbe_ram.sv
hdl/huffman_byte_encoder_top.sv
bench/testbench.sv
